/* hdl/smma_pkg.sv */
// Shared widths, operation and register codes, and control structs for the scaled GEMM block.
package smma_pkg;

  localparam int MAX_DIM_DEFAULT = 16;

  localparam int ELEM_W     = 16;
  localparam int RES_W      = 32;
  localparam int IDX_W      = 4;
  localparam int DIM_REG_W  = 5;
  localparam int GAIN_W     = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_C = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = 3'd4;

  localparam logic [DIM_REG_W-1:0]     DIM_RESET   = 5'd16;
  localparam logic signed [GAIN_W-1:0] ALPHA_RESET = 16'sd256;
  localparam logic signed [GAIN_W-1:0] BETA_RESET  = 16'sd0;

  // decoded input transaction, seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_store;
    logic            in_range;
  } smma_req_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_a;
    logic load_b;
    logic load_c;
    logic start;
    logic issue;
    logic scale;
    logic finish;
    logic oor;
  } smma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic kk_zero;
    logic k_last;
  } smma_stat_t;

endpackage

/* hdl/smma_ctrl.sv */
// Sequencer for the scaled GEMM block: clear pass, loads, dot-product walk and result hand-off.
module smma_ctrl
  import smma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  smma_req_t  req,
  output logic       out_valid,
  input  logic       out_ready,
  output smma_cmd_t  cmd,
  input  smma_stat_t stat
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_DRAIN1 = 3'd3;
  localparam logic [2:0] ST_DRAIN2 = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       oor;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_LOAD_A: cmd.load_a = req.in_store;
            OP_LOAD_B: cmd.load_b = req.in_store;
            OP_LOAD_C: cmd.load_c = req.in_store;
            OP_READ: begin
              cmd.start = 1'b1;
              if (!req.in_range) begin
                state_next = ST_FINISH;
              end else if (stat.kk_zero) begin
                state_next = ST_DRAIN1;
              end else begin
                state_next = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.k_last) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_SCALE;
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          cmd.oor    = oor;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the range verdict of the read in flight
  always_ff @(posedge clk) begin
    if (accept && req.op == OP_READ) begin
      oor <= !req.in_range;
    end
  end

endmodule

/* hdl/smma_dp.sv */
// Datapath for the scaled GEMM block: element stores, shared MAC unit, scaling and saturation.
module smma_dp
  import smma_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  smma_cmd_t                           cmd,
  output smma_stat_t                          stat,
  input  logic [IDX_W-1:0]                    row_index,
  input  logic [IDX_W-1:0]                    col_index,
  input  logic signed [ELEM_W-1:0]            elem_value,
  input  logic [$clog2(MAX_DIM+1)-1:0]        kk,
  input  logic signed [GAIN_W-1:0]            alpha,
  input  logic signed [GAIN_W-1:0]            beta,
  output logic signed [RES_W-1:0]             result_value,
  output logic                                saturated,
  output logic                                out_of_range
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = $clog2(MAX_DIM);
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int DOT_W   = 2 * ELEM_W + $clog2(MAX_DIM);
  localparam int APROD_W = DOT_W + GAIN_W;
  localparam int TOT_W   = APROD_W + 1;
  localparam int SH_W    = TOT_W - 8;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] c_mem [DEPTH];

  logic [AW-1:0]               clr_addr;
  logic [DW-1:0]               k;
  logic [IW-1:0]               row_q;
  logic [IW-1:0]               col_q;
  logic signed [ELEM_W-1:0]    a_q;
  logic signed [ELEM_W-1:0]    b_q;
  logic signed [ELEM_W-1:0]    c_q;
  logic signed [2*ELEM_W-1:0]  prod;
  logic                        v1;
  logic                        v2;
  logic signed [DOT_W-1:0]     acc;
  logic signed [APROD_W-1:0]   alpha_prod;
  logic signed [2*ELEM_W-1:0]  beta_prod;

  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rc_addr;
  logic [AW-1:0]               a_rd_addr;
  logic [AW-1:0]               b_rd_addr;
  logic signed [TOT_W-1:0]     total;
  logic signed [SH_W-1:0]      shifted;
  logic [SH_W-RES_W:0]         upper;
  logic                        overflow;

  // row pitch of every store is MAX_DIM
  assign wr_addr   = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
  assign rc_addr   = AW'(32'(row_q) * MAX_DIM + 32'(col_q));
  assign a_rd_addr = AW'(32'(row_q) * MAX_DIM + 32'(k[IW-1:0]));
  assign b_rd_addr = AW'(32'(k[IW-1:0]) * MAX_DIM + 32'(col_q));

  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.kk_zero    = (kk == '0);
  assign stat.k_last     = ((k + DW'(1)) == kk);

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_mem[wr_addr] <= elem_value;
    end
    a_q <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b) begin
      b_mem[wr_addr] <= elem_value;
    end
    b_q <= b_mem[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      c_mem[clr_addr] <= '0;
    end else if (cmd.load_c) begin
      c_mem[wr_addr] <= elem_value;
    end
    c_q <= c_mem[rc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= IW'(row_index);
      col_q <= IW'(col_index);
      k     <= '0;
      acc   <= '0;
    end else begin
      if (cmd.issue) begin
        k <= k + DW'(1);
      end
      if (v2) begin
        acc <= acc + DOT_W'(prod);
      end
    end
    prod      <= a_q * b_q;
    beta_prod <= beta * c_q;
    if (cmd.scale) begin
      alpha_prod <= acc * alpha;
    end
  end

  // round half up at 2^-8, then clip to 32 bits
  always_comb begin
    total    = TOT_W'(alpha_prod) + (TOT_W'(beta_prod) <<< 8) + TOT_W'(128);
    shifted  = total[TOT_W-1:8];
    upper    = shifted[SH_W-1:RES_W-1];
    overflow = (upper != '0) && (upper != '1);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd.oor) begin
        result_value <= '0;
        saturated    <= 1'b0;
        out_of_range <= 1'b1;
      end else begin
        out_of_range <= 1'b0;
        saturated    <= overflow;
        if (!overflow) begin
          result_value <= shifted[RES_W-1:0];
        end else if (shifted[SH_W-1]) begin
          result_value <= {1'b1, {(RES_W-1){1'b0}}};
        end else begin
          result_value <= {1'b0, {(RES_W-1){1'b1}}};
        end
      end
    end
  end

endmodule

/* hdl/scaled_matrix_multiply_accumulate_top.sv */
// Top level of the scaled GEMM block: stream ports, configuration registers, controller and datapath.
// s_tready stays high after a load, so loads can follow back to back.
// An in-range read steps through RUN, DRAIN1, DRAIN2, SCALE and FINISH before m_tvalid rises;
// RUN walks K = min(inner_k, MAX_DIM) terms on the single MAC unit and is skipped when K is zero;
// one read is in flight at a time. Out-of-range reads go straight from acceptance to FINISH.
// After rst a clearing pass zeroes all MAX_DIM*MAX_DIM entries of the C store (256 by default),
// with s_tready low; configuration writes are taken during the pass.
module scaled_matrix_multiply_accumulate_top
  import smma_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // row_index[3:0], col_index[7:4], elem_value[23:8]
  input  logic [1:0]            s_tuser,   // op[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // result_value[31:0]
  output logic [1:0]            m_tuser,   // saturated[0], out_of_range[1]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);

  // configuration registers
  logic [DIM_REG_W-1:0]     rows_m;
  logic [DIM_REG_W-1:0]     cols_n;
  logic [DIM_REG_W-1:0]     inner_k;
  logic signed [GAIN_W-1:0] alpha_gain;
  logic signed [GAIN_W-1:0] beta_gain;

  // dimensions clipped to the store size
  logic [DW-1:0] rows_eff;
  logic [DW-1:0] cols_eff;
  logic [DW-1:0] kk_eff;

  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] elem_value;

  smma_req_t  req;
  smma_cmd_t  cmd;
  smma_stat_t stat;

  logic signed [RES_W-1:0] result_value;
  logic                    saturated;
  logic                    out_of_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m     <= DIM_RESET;
      cols_n     <= DIM_RESET;
      inner_k    <= DIM_RESET;
      alpha_gain <= ALPHA_RESET;
      beta_gain  <= BETA_RESET;
    end else if (cfg_we) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_index)
        REG_ROWS_M:     rows_m     <= cfg_data[DIM_REG_W-1:0];
        REG_COLS_N:     cols_n     <= cfg_data[DIM_REG_W-1:0];
        REG_INNER_K:    inner_k    <= cfg_data[DIM_REG_W-1:0];
        REG_ALPHA_GAIN: alpha_gain <= cfg_data[GAIN_W-1:0];
        REG_BETA_GAIN:  beta_gain  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rows_eff = (32'(rows_m) > MAX_DIM)  ? DW'(MAX_DIM) : DW'(rows_m);
  assign cols_eff = (32'(cols_n) > MAX_DIM)  ? DW'(MAX_DIM) : DW'(cols_n);
  assign kk_eff   = (32'(inner_k) > MAX_DIM) ? DW'(MAX_DIM) : DW'(inner_k);

  // unpack the input transaction
  assign row_index  = s_tdata[3:0];
  assign col_index  = s_tdata[7:4];
  assign elem_value = s_tdata[23:8];

  // loads outside the store are dropped; reads outside M or N answer zero
  assign req.op       = s_tuser;
  assign req.in_store = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign req.in_range = (32'(row_index) < 32'(rows_eff)) && (32'(col_index) < 32'(cols_eff));

  smma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  smma_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .row_index    (row_index),
    .col_index    (col_index),
    .elem_value   (elem_value),
    .kk           (kk_eff),
    .alpha        (alpha_gain),
    .beta         (beta_gain),
    .result_value (result_value),
    .saturated    (saturated),
    .out_of_range (out_of_range)
  );

  // pack the result transaction
  assign m_tdata = result_value;
  assign m_tuser = {out_of_range, saturated};

endmodule

/* hdl/smma_checker.sv */
// Port-level assertions for the scaled GEMM block, bound to its top level.
module smma_checker
  import smma_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [1:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [31:0]           m_tdata,
  input logic [1:0]            m_tuser
);

  // reset starts the clearing pass with nothing pending on the output
  a_reset_quiet: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input ready or output valid right after reset");

  // one read in flight: a read transaction closes the input for the next cycle
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_READ) |=> !s_tready)
    else $error("input accepted while a read is being computed");

  // out-of-range answers carry zero and no saturation
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == 32'h0 && !m_tuser[0]))
    else $error("out-of-range result not zero");

  // a clipped result sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'h7fffffff || m_tdata == 32'h80000000))
    else $error("saturated result not at a rail");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind scaled_matrix_multiply_accumulate_top smma_checker u_smma_checker (.*);
